@@ hdl/hfua_pkg.sv @@
// Shared types and constants for the H.264 FU-A packetizer.
package hfua_pkg;

    localparam int PL_W = 11;

    localparam logic [PL_W-1:0] CAP_MIN   = 11'd16;
    localparam logic [PL_W-1:0] CAP_MAX   = 11'd1460;
    localparam logic [PL_W-1:0] CAP_RESET = 11'd1420;
    localparam logic [PL_W-1:0] FU_BYTES  = 11'd2;

    localparam logic [7:0] NRI_F_MASK = 8'hE0;
    localparam logic [7:0] TYPE_FUA   = 8'd28;
    localparam logic [7:0] FU_S_BIT   = 8'h80;
    localparam logic [7:0] FU_E_BIT   = 8'h40;
    localparam logic [7:0] TYPE_MASK  = 8'h1F;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [7:0]      data;
        logic            prefix;
        logic [7:0]      fu_ind;
        logic [7:0]      fu_hdr;
        logic            pkt_start;
        logic            pkt_end;
        logic            mark;
        logic [PL_W-1:0] pkt_len;
        logic [31:0]     stamp;
        logic            channel;
        logic [3:0]      kind;
    } t_entry;

endpackage

@@ hdl/hfua_front.sv @@
// Front end: takes NAL bytes, tracks packet and fragment state, queues output work.
module hfua_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [10:0]            i_cfg_wdata,
    input  logic                   i_accept,
    input  logic [7:0]             i_nal_byte,
    input  logic                   i_first,
    input  logic [LENGTH_BITS-1:0] i_frame_length,
    input  logic [31:0]            i_frame_time,
    input  logic                   i_channel,
    input  logic [3:0]             i_kind,
    output logic                   o_push,
    output hfua_pkg::t_entry       o_entry
);
    import hfua_pkg::*;

    logic [PL_W-1:0]        r_cap, r_chunk;
    logic                   r_frag, n_frag;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [PL_W-1:0]        r_left, n_left;
    logic [PL_W-1:0]        r_pkt_len, n_pkt_len;
    logic [7:0]             r_fu_ind, n_fu_ind;
    logic [4:0]             r_nal_type, n_nal_type;
    logic                   r_first_frag, n_first_frag;
    logic [31:0]            r_stamp, n_stamp;
    logic                   r_channel, n_channel;
    logic [3:0]             r_kind, n_kind;

    logic [LENGTH_BITS-1:0] len;
    logic                   fits;
    logic                   rem_gt;
    logic [PL_W-1:0]        cnt;
    logic [PL_W-1:0]        sat_cap;

    always_comb begin
        if (i_cfg_wdata < CAP_MIN) begin
            sat_cap = CAP_MIN;
        end else if (i_cfg_wdata > CAP_MAX) begin
            sat_cap = CAP_MAX;
        end else begin
            sat_cap = i_cfg_wdata;
        end
    end

    assign len    = (i_frame_length == '0) ? LENGTH_BITS'(1) : i_frame_length;
    assign fits   = len <= LENGTH_BITS'(r_cap);
    assign rem_gt = r_rem > LENGTH_BITS'(r_chunk);
    assign cnt    = rem_gt ? r_chunk : r_rem[PL_W-1:0];

    always_comb begin
        n_frag       = r_frag;
        n_rem        = r_rem;
        n_left       = r_left;
        n_pkt_len    = r_pkt_len;
        n_fu_ind     = r_fu_ind;
        n_nal_type   = r_nal_type;
        n_first_frag = r_first_frag;
        n_stamp      = r_stamp;
        n_channel    = r_channel;
        n_kind       = r_kind;
        o_push       = 1'b0;
        o_entry.data      = i_nal_byte;
        o_entry.prefix    = 1'b0;
        o_entry.fu_ind    = r_fu_ind;
        o_entry.fu_hdr    = '0;
        o_entry.pkt_start = 1'b0;
        o_entry.pkt_end   = 1'b0;
        o_entry.mark      = 1'b0;
        o_entry.pkt_len   = r_pkt_len;
        o_entry.stamp     = r_stamp;
        o_entry.channel   = r_channel;
        o_entry.kind      = r_kind;
        if (i_accept) begin
            if (i_first) begin
                n_stamp      = i_frame_time;
                n_channel    = i_channel;
                n_kind       = i_kind;
                n_first_frag = 1'b1;
                n_rem        = len - LENGTH_BITS'(1);
                if (fits) begin
                    n_frag            = 1'b0;
                    n_left            = len[PL_W-1:0] - PL_W'(1);
                    n_pkt_len         = len[PL_W-1:0];
                    o_push            = 1'b1;
                    o_entry.pkt_start = 1'b1;
                    o_entry.pkt_end   = (len == LENGTH_BITS'(1));
                    o_entry.mark      = 1'b1;
                    o_entry.pkt_len   = len[PL_W-1:0];
                    o_entry.stamp     = i_frame_time;
                    o_entry.channel   = i_channel;
                    o_entry.kind      = i_kind;
                end else begin
                    n_frag     = 1'b1;
                    n_fu_ind   = (i_nal_byte & NRI_F_MASK) | TYPE_FUA;
                    n_nal_type = i_nal_byte[4:0];
                    n_left     = '0;
                end
            end else if (r_rem != '0) begin
                o_push = 1'b1;
                n_rem  = r_rem - LENGTH_BITS'(1);
                if (r_frag && r_left == '0) begin
                    o_entry.prefix  = 1'b1;
                    o_entry.fu_hdr  = ({3'b000, r_nal_type} & TYPE_MASK)
                                    | (r_first_frag ? FU_S_BIT : 8'h00)
                                    | (rem_gt ? 8'h00 : FU_E_BIT);
                    o_entry.mark    = !rem_gt;
                    o_entry.pkt_end = (cnt == PL_W'(1));
                    o_entry.pkt_len = cnt + FU_BYTES;
                    n_pkt_len       = cnt + FU_BYTES;
                    n_left          = cnt - PL_W'(1);
                    n_first_frag    = 1'b0;
                end else begin
                    o_entry.mark      = r_frag ? (r_rem == LENGTH_BITS'(r_left)) : 1'b1;
                    o_entry.pkt_start = !r_frag && (r_left == r_pkt_len);
                    o_entry.pkt_end   = (r_left == PL_W'(1));
                    n_left            = r_left - PL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= CAP_RESET;
            r_chunk      <= CAP_RESET - FU_BYTES;
            r_frag       <= 1'b0;
            r_rem        <= '0;
            r_left       <= '0;
            r_pkt_len    <= '0;
            r_fu_ind     <= '0;
            r_nal_type   <= '0;
            r_first_frag <= 1'b1;
            r_stamp      <= '0;
            r_channel    <= 1'b0;
            r_kind       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= sat_cap;
                r_chunk <= sat_cap - FU_BYTES;
            end
            r_frag       <= n_frag;
            r_rem        <= n_rem;
            r_left       <= n_left;
            r_pkt_len    <= n_pkt_len;
            r_fu_ind     <= n_fu_ind;
            r_nal_type   <= n_nal_type;
            r_first_frag <= n_first_frag;
            r_stamp      <= n_stamp;
            r_channel    <= n_channel;
            r_kind       <= n_kind;
        end
    end

    a_single_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frag |-> (r_rem == LENGTH_BITS'(r_left)))
        else $error("single-packet byte counters diverged");

endmodule

@@ hdl/hfua_queue.sv @@
// Short work queue between the front end and the byte emitter.
module hfua_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hfua_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output hfua_pkg::t_entry o_entry
);
    import hfua_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

@@ hdl/hfua_back.sv @@
// Back end: expands queued work into payload beats behind an output register.
module hfua_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hfua_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [55:0]      o_tdata,
    output logic [7:0]       o_tuser,
    output logic             o_tlast
);
    import hfua_pkg::*;

    localparam logic [1:0] PH_IND  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]      r_phase, n_phase;
    logic            r_valid;
    logic [7:0]      r_byte, n_byte;
    logic            r_start, n_start;
    logic            r_end, n_end;
    logic            r_last, n_last;
    logic            r_mark;
    logic [PL_W-1:0] r_pkt_len;
    logic [31:0]     r_stamp;
    logic            r_channel;
    logic [3:0]      r_kind;
    logic            load;

    assign load = i_valid && (!r_valid || i_tready);

    always_comb begin
        n_phase = PH_IND;
        n_byte  = i_entry.data;
        n_start = i_entry.pkt_start;
        n_end   = i_entry.pkt_end;
        n_last  = 1'b1;
        o_pop   = load;
        if (i_entry.prefix) begin
            case (r_phase)
                PH_IND: begin
                    n_phase = PH_HDR;
                    n_byte  = i_entry.fu_ind;
                    n_start = 1'b1;
                    n_end   = 1'b0;
                    n_last  = 1'b0;
                    o_pop   = 1'b0;
                end
                PH_HDR: begin
                    n_phase = PH_DATA;
                    n_byte  = i_entry.fu_hdr;
                    n_start = 1'b0;
                    n_end   = 1'b0;
                    n_last  = 1'b0;
                    o_pop   = 1'b0;
                end
                default: begin
                    n_phase = PH_IND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IND;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= n_byte;
            r_start   <= n_start;
            r_end     <= n_end;
            r_last    <= n_last;
            r_mark    <= i_entry.mark;
            r_pkt_len <= i_entry.pkt_len;
            r_stamp   <= i_entry.stamp;
            r_channel <= i_entry.channel;
            r_kind    <= i_entry.kind;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {5'b00000, r_stamp, r_pkt_len, r_byte};
    assign o_tuser  = {r_kind, r_channel, r_mark, r_end, r_start};
    assign o_tlast  = r_last;

    a_phase_needs_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IND) |-> (i_valid && i_entry.prefix))
        else $error("FU expansion in progress without a fragment-start entry");

endmodule

@@ hdl/h264_fua_rtp_packetizer_top.sv @@
// H.264 RTP packetizer (single NAL unit or FU-A fragments), payload bytes only.
// An accepted beat is queued, then loaded into the output register that drives m_axis.
// Throughput: one input beat per cycle while the queue has room; the first data byte
// of each fragment emits three beats, so once the 4-entry queue fills the input stalls
// (the header byte of a fragmented NAL emits nothing).
// Reset: synchronous active-low; max_payload returns to 1420 and all NAL state clears.
module h264_fua_rtp_packetizer_top #(
    parameter  int LENGTH_BITS = 24,
    localparam int IN_DW       = ((40 + LENGTH_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [10:0]      i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // nal_byte, frame_length, frame_time, zero pad
    input  logic [IN_DW-1:0] s_axis_tdata,
    // first_of_frame, channel_id, frame_kind
    input  logic [5:0]       s_axis_tuser,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // payload_byte, packet_bytes, stamp, zero pad
    output logic [55:0]      m_axis_tdata,
    // packet_start, packet_end, marker, channel_out, kind_out
    output logic [7:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    import hfua_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    t_entry push_entry;
    t_entry head_entry;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    hfua_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_nal_byte     (s_axis_tdata[7:0]),
        .i_first        (s_axis_tuser[0]),
        .i_frame_length (s_axis_tdata[8 +: LENGTH_BITS]),
        .i_frame_time   (s_axis_tdata[8 + LENGTH_BITS +: 32]),
        .i_channel      (s_axis_tuser[1]),
        .i_kind         (s_axis_tuser[5:2]),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    hfua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_entry (head_entry)
    );

    hfua_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the H.264 FU-A RTP packetizer: directed table, then random NALs.
`timescale 1ns / 100ps

module testbench;
    import hfua_pkg::*;

    localparam int DIR_ROWS = 17;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int DRAIN = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_SEND = 60;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        first;
        logic        last;
        logic [23:0] length;
        logic [31:0] ftime;
        logic        chan;
        logic [3:0]  kind;
    } t_nal_beat;

    typedef struct packed {
        logic [7:0]      pbyte;
        logic            pstart;
        logic            pend;
        logic            marker;
        logic [PL_W-1:0] pbytes;
        logic [31:0]     stamp;
        logic            chan;
        logic [3:0]      kind;
        logic            run_last;
    } t_pay_beat;

    typedef enum logic [1:0] {BY_MODEL, NO_BEAT, ONE_BEAT} t_row_check;

    typedef struct packed {
        t_nal_beat  beat;
        t_row_check check;
        t_pay_beat  want;
    } t_dir_row;

    localparam t_pay_beat NO_WANT = '0;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{8'h5A, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, NO_BEAT, NO_WANT},
        '{'{8'hFF, 1'b1, 1'b1, 24'd1, 32'hFFFF_FFFF, 1'b1, 4'hF}, ONE_BEAT,
          '{8'hFF, 1'b1, 1'b1, 1'b1, 11'd1, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b1}},
        '{'{8'h00, 1'b1, 1'b1, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, ONE_BEAT,
          '{8'h00, 1'b1, 1'b1, 1'b1, 11'd1, 32'h0000_0000, 1'b0, 4'h0, 1'b1}},
        '{'{8'hA5, 1'b0, 1'b1, 24'hFF_FFFF, 32'h1234_5678, 1'b1, 4'h5}, NO_BEAT, NO_WANT},
        '{'{8'h65, 1'b1, 1'b0, 24'd3, 32'h0000_0001, 1'b0, 4'h2}, BY_MODEL, NO_WANT},
        '{'{8'h88, 1'b0, 1'b0, 24'd3, 32'h0000_0000, 1'b0, 4'h2}, BY_MODEL, NO_WANT},
        '{'{8'h99, 1'b0, 1'b1, 24'd3, 32'h0000_0000, 1'b0, 4'h2}, BY_MODEL, NO_WANT},
        '{'{8'h3C, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, NO_BEAT, NO_WANT},
        '{'{8'h41, 1'b1, 1'b0, 24'd1420, 32'h8000_0000, 1'b1, 4'hA}, BY_MODEL, NO_WANT},
        '{'{8'h7E, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, BY_MODEL, NO_WANT},
        '{'{8'h7C, 1'b1, 1'b0, 24'hFF_FFFF, 32'h5555_5555, 1'b0, 4'h3}, NO_BEAT, NO_WANT},
        '{'{8'h00, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, BY_MODEL, NO_WANT},
        '{'{8'hFF, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, BY_MODEL, NO_WANT},
        '{'{8'hE5, 1'b1, 1'b0, 24'd1421, 32'hAAAA_AAAA, 1'b1, 4'hC}, NO_BEAT, NO_WANT},
        '{'{8'h11, 1'b0, 1'b0, 24'd0, 32'h0000_0000, 1'b0, 4'h0}, BY_MODEL, NO_WANT},
        '{'{8'h09, 1'b1, 1'b0, 24'd2, 32'hA5A5_A5A5, 1'b0, 4'h6}, BY_MODEL, NO_WANT},
        '{'{8'h22, 1'b0, 1'b1, 24'd2, 32'h0000_0000, 1'b0, 4'h0}, BY_MODEL, NO_WANT}
    };

    localparam logic [PL_W-1:0] CAP_STEPS [PHASES] = '{
        CAP_MIN, 11'd0, 11'd17, 11'd40, 11'h7FF, CAP_MAX, 11'd0, 11'd0, CAP_RESET
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [5:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    logic        m_axis_tlast;

    h264_fua_rtp_packetizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Packetizer state as predicted
    logic [PL_W-1:0] cap_reg = CAP_RESET;
    logic            frag_on = 1'b0;
    int              remain = 0;
    int              pkt_left = 0;
    logic [7:0]      fu_ind = '0;
    logic [4:0]      nal_typ = '0;
    logic            first_frag = 1'b1;
    logic [31:0]     h_stamp = '0;
    logic            h_chan = 1'b0;
    logic [3:0]      h_kind = '0;
    int              pkt_len = 0;

    t_pay_beat payload_expect[$];
    int        mismatches = 0;
    int        items_fed = 0;
    int        bytes_in = 0;
    int        beats_out = 0;
    bit        gaps_on = 1'b1;
    bit        hold_req = 1'b0;
    t_pay_beat seen_beat;
    t_pay_beat want_beat;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic int eff_cap();
        int c;
        c = int'(cap_reg);
        if (c < int'(CAP_MIN)) c = int'(CAP_MIN);
        if (c > int'(CAP_MAX)) c = int'(CAP_MAX);
        return c;
    endfunction

    function automatic t_pay_beat payload_beat(logic [7:0] v, logic st, logic en, logic mk);
        t_pay_beat p;
        p.pbyte = v;
        p.pstart = st;
        p.pend = en;
        p.marker = mk;
        p.pbytes = PL_W'(pkt_len);
        p.stamp = h_stamp;
        p.chan = h_chan;
        p.kind = h_kind;
        p.run_last = 1'b0;
        return p;
    endfunction

    task automatic predict_payload(input t_nal_beat b, input bit keep);
        t_pay_beat  outb [3];
        int         n;
        int         len;
        int         chunk;
        logic [7:0] hdr;
        logic       mark;
        n = 0;
        len = int'(b.length);
        if (b.first || remain != 0) items_fed++;
        if (b.first) begin
            if (len == 0) len = 1;
            h_stamp = b.ftime;
            h_chan = b.chan;
            h_kind = b.kind;
            first_frag = 1'b1;
            if (len <= eff_cap()) begin
                frag_on = 1'b0;
                remain = len;
                pkt_left = len;
                pkt_len = len;
            end else begin
                frag_on = 1'b1;
                fu_ind = (b.nal_byte & NRI_F_MASK) | TYPE_FUA;
                nal_typ = b.nal_byte[4:0];
                remain = len - 1;
                pkt_left = 0;
                return;
            end
        end else if (remain == 0) begin
            return;
        end

        if (frag_on && pkt_left == 0) begin
            chunk = eff_cap() - int'(FU_BYTES);
            hdr = {3'b000, nal_typ} & TYPE_MASK;
            if (first_frag) hdr = hdr | FU_S_BIT;
            if (remain <= chunk) hdr = hdr | FU_E_BIT;
            pkt_left = (remain > chunk) ? chunk : remain;
            pkt_len = pkt_left + int'(FU_BYTES);
            mark = (remain == pkt_left);
            outb[0] = payload_beat(fu_ind, 1'b1, 1'b0, mark);
            outb[1] = payload_beat(hdr, 1'b0, 1'b0, mark);
            first_frag = 1'b0;
            outb[2] = payload_beat(b.nal_byte, 1'b0, pkt_left == 1, mark);
            n = 3;
        end else if (frag_on) begin
            outb[0] = payload_beat(b.nal_byte, 1'b0, pkt_left == 1, remain == pkt_left);
            n = 1;
        end else begin
            outb[0] = payload_beat(b.nal_byte, pkt_left == pkt_len, pkt_left == 1, 1'b1);
            n = 1;
        end

        if (pkt_left > 0) pkt_left--;
        if (remain > 0) remain--;
        outb[n-1].run_last = 1'b1;
        if (keep) begin
            for (int k = 0; k < n; k++) payload_expect.push_back(outb[k]);
        end
    endtask

    task automatic send_beat(input t_nal_beat b, input t_row_check check, input t_pay_beat want);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b.ftime, b.length, b.nal_byte};
        s_axis_tuser <= {b.kind, b.chan, b.first};
        s_axis_tlast <= b.last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_in++;
        predict_payload(b, check == BY_MODEL);
        if (check == ONE_BEAT) payload_expect.push_back(want);
    endtask

    task automatic random_nal();
        t_nal_beat b;
        int        c;
        int        len;
        int        eff;
        int        nsend;
        c = eff_cap();
        case ($urandom_range(0, 9))
            0: len = 0;
            1, 2: len = $urandom_range(1, 4);
            3, 4: len = c - 2 + $urandom_range(0, 4);
            5, 6: len = $urandom_range(1, 2) * (c - int'(FU_BYTES)) + $urandom_range(0, 2);
            7: len = $urandom_range(5, 3 * c);
            8: len = $urandom & 32'h00FF_FFFF;
            default: len = $urandom_range(2, c);
        endcase
        eff = (len == 0) ? 1 : len;
        nsend = (eff > MAX_SEND) ? $urandom_range(1, MAX_SEND) : eff;
        // cut the NAL short now and then; the next header abandons it
        if (nsend > 1 && $urandom_range(0, 9) == 0) nsend = $urandom_range(1, nsend - 1);
        for (int k = 0; k < nsend; k++) begin
            b.nal_byte = 8'($urandom);
            b.first = (k == 0);
            b.last = (k == eff - 1) ^ ($urandom_range(0, 7) == 0);
            b.length = 24'(len);
            b.ftime = $urandom;
            b.chan = 1'($urandom);
            b.kind = 4'($urandom);
            send_beat(b, BY_MODEL, NO_WANT);
        end
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                b = t_nal_beat'(72'({$urandom, $urandom, $urandom}));
                b.first = 1'b0;
                send_beat(b, BY_MODEL, NO_WANT);
            end
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (payload_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            seen_beat.pbyte = m_axis_tdata[7:0];
            seen_beat.pbytes = m_axis_tdata[18:8];
            seen_beat.stamp = m_axis_tdata[50:19];
            seen_beat.pstart = m_axis_tuser[0];
            seen_beat.pend = m_axis_tuser[1];
            seen_beat.marker = m_axis_tuser[2];
            seen_beat.chan = m_axis_tuser[3];
            seen_beat.kind = m_axis_tuser[7:4];
            seen_beat.run_last = m_axis_tlast;
            if (payload_expect.size() == 0) begin
                $error("unexpected payload beat %0h", seen_beat.pbyte);
                mismatches++;
            end else begin
                want_beat = payload_expect.pop_front();
                check_field("payload_byte", 32'(want_beat.pbyte), 32'(seen_beat.pbyte));
                check_field("packet_start", 32'(want_beat.pstart), 32'(seen_beat.pstart));
                check_field("packet_end", 32'(want_beat.pend), 32'(seen_beat.pend));
                check_field("marker", 32'(want_beat.marker), 32'(seen_beat.marker));
                check_field("packet_bytes", 32'(want_beat.pbytes), 32'(seen_beat.pbytes));
                check_field("stamp", want_beat.stamp, seen_beat.stamp);
                check_field("channel_out", 32'(want_beat.chan), 32'(seen_beat.chan));
                check_field("kind_out", 32'(want_beat.kind), 32'(seen_beat.kind));
                check_field("run_last", 32'(want_beat.run_last), 32'(seen_beat.run_last));
            end
        end
    end

    initial begin : sink
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [PL_W-1:0] cap_w;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(DIR_TABLE[i].beat, DIR_TABLE[i].check, DIR_TABLE[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 6)
                cap_w = PL_W'($urandom_range(CAP_MIN, CAP_MAX));
            else if (ph == 7)
                cap_w = PL_W'($urandom);
            else
                cap_w = CAP_STEPS[ph];
            i_cfg_wdata <= cap_w;
            i_cfg_we <= 1'b1;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cap_reg = cap_w;
            gaps_on = (ph != 3) && (ph < 7);
            // stall the sink long enough to back the block up
            if (ph == 1) hold_req = 1'b1;
            while (items_fed < DIR_ROWS + ITEMS_PER_PHASE * (ph + 1)) random_nal();
        end

        settle();
        $display("Run fed %0d NAL bytes and checked %0d payload beats across %0d payload limits,",
                 bytes_in, beats_out, PHASES + 1);
        $display("covering pass-through NALs, FU-A fragments, abandoned NALs and stray bytes.");
        if (mismatches == 0 && payload_expect.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ h264_fua_rtp_packetizer_top.f @@
hdl/hfua_pkg.sv
hdl/hfua_front.sv
hdl/hfua_queue.sv
hdl/hfua_back.sv
hdl/h264_fua_rtp_packetizer_top.sv
sim/testbench.sv
